// ===== hw/rtl/ssed_pkg.sv =====
package ssed_pkg;

    // Sample and geometry limits.
    localparam int unsigned SAMPLE_BITS = 16;
    localparam int unsigned MAX_WIDTH   = 4096;
    localparam int unsigned MAX_HEIGHT  = 4096;
    localparam int unsigned MIN_DIM     = 3;
    localparam int unsigned DIM_BITS    = 13;
    localparam int unsigned POS_BITS    = 12;
    localparam int unsigned ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int unsigned OCT_BITS    = 3;

    // Window shape: scales, rows, columns, and samples seen by one lane.
    localparam int unsigned NUM_SCALES  = 3;
    localparam int unsigned WIN_DIM     = 3;
    localparam int unsigned LANE_TAPS   = WIN_DIM * WIN_DIM;

    // Result queue.
    localparam int unsigned FIFO_DEPTH    = 4;
    localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OCTAVE_INDEX = 2'd2;

    localparam logic [DIM_BITS-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [DIM_BITS-1:0] RESET_HEIGHT = 13'd480;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef sample_t [NUM_SCALES-1:0] scale_set_t;

    // One column of the line store: the two previous rows for all scales.
    typedef struct packed {
        scale_set_t older;
        scale_set_t newer;
    } line_word_t;

    // What one comparison lane reports about its nine samples.
    typedef struct packed {
        logic below;
        logic above;
    } lane_flags_t;

    // One keypoint; packed so that the column lands in the lowest bits.
    typedef struct packed {
        logic [OCT_BITS-1:0] octave;
        sample_t             value;
        logic [POS_BITS-1:0] row;
        logic [POS_BITS-1:0] col;
    } key_t;

endpackage

// ===== hw/rtl/ssed_line_buffer.sv =====
module ssed_line_buffer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [ssed_pkg::ADDR_BITS-1:0]      rd_addr,
    input  logic                                wr_en,
    input  logic [ssed_pkg::ADDR_BITS-1:0]      wr_addr,
    input  ssed_pkg::line_word_t                wr_data,
    output ssed_pkg::line_word_t                rd_data
);

    ssed_pkg::line_word_t line_mem_reg [ssed_pkg::MAX_WIDTH];
    ssed_pkg::line_word_t rd_raw_reg;
    ssed_pkg::line_word_t fwd_data_reg;
    logic                 fwd_hit_reg;
    logic                 fwd_hit_next;

    // A read and a write of the same column in one cycle must return the new word.
    assign fwd_hit_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= line_mem_reg[rd_addr];
        end
        if (fwd_hit_next)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_raw_reg;

endmodule

// ===== hw/rtl/ssed_lane.sv =====
module ssed_lane
(
    input  ssed_pkg::sample_t     taps [ssed_pkg::LANE_TAPS],
    input  ssed_pkg::sample_t     centre,
    output ssed_pkg::lane_flags_t flags
);

    always_comb
    begin
        flags = '0;
        for (int k = 0; k < ssed_pkg::LANE_TAPS; k++)
        begin
            if (taps[k] < centre)
            begin
                flags.below = 1'b1;
            end
            if (taps[k] > centre)
            begin
                flags.above = 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/ssed_out_fifo.sv =====
module ssed_out_fifo
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  ssed_pkg::key_t                       push_data,
    output logic                                 tvalid,
    input  logic                                 tready,
    output ssed_pkg::key_t                       head,
    output logic [ssed_pkg::FIFO_CNT_BITS-1:0]   count
);

    ssed_pkg::key_t                         entry_reg [ssed_pkg::FIFO_DEPTH];
    logic [ssed_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_reg;
    logic [ssed_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_reg;
    logic [ssed_pkg::FIFO_CNT_BITS-1:0]     count_reg;
    logic [ssed_pkg::FIFO_CNT_BITS-1:0]     count_next;
    logic                                   pop;

    assign tvalid = (count_reg != '0);
    assign pop    = tvalid && tready;
    assign head   = entry_reg[rd_ptr_reg];
    assign count  = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/scale_space_extrema_detector_unit.sv =====
// Scale-space extrema detector: 3x3x3 difference-of-Gaussian extremum test.
//
// Input channel (s_*): one pixel position per transaction in raster order.
// s_tdata carries the middle, lower and upper scale samples; s_tuser marks
// the top-left pixel of a frame and restarts the row and column counters.
// Output channel (m_*): one transaction per keypoint, carrying column, row,
// middle-scale response and the configured octave number.
// Configuration (cfg_*): frame width, frame height and octave index, to be
// written only while the block is idle; the block itself does not enforce this.
//
// Throughput is one pixel per clock while s_tready is high. A keypoint reaches m_*
// after its completing pixel is accepted: the line store column is read in stage 1,
// the window shifts, then the 27 comparisons (three lanes of nine)
// feed the result queue. Reset clears the counters, window, pipeline and the
// queue and restores 640 x 480, octave 0; the line store is not cleared.
// When the receiver stalls, keypoints collect in a four-entry queue and
// s_tready falls once the queue plus in-flight pixels could fill it.
module scale_space_extrema_detector_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Pixel input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,  // sample_mid, sample_below, sample_above
    input  logic                                 s_tuser,  // first_of_frame
    // Keypoint output stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [47:0]                          m_tdata,  // key_col, key_row, key_value, key_octave
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [ssed_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ssed_pkg::DIM_BITS-1:0]        cfg_data
);

    localparam int unsigned NS = ssed_pkg::NUM_SCALES;
    localparam int unsigned WD = ssed_pkg::WIN_DIM;

    // Configuration registers.
    logic [ssed_pkg::DIM_BITS-1:0]  width_reg;
    logic [ssed_pkg::DIM_BITS-1:0]  height_reg;
    logic [ssed_pkg::OCT_BITS-1:0]  octave_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ssed_pkg::RESET_WIDTH;
            height_reg <= ssed_pkg::RESET_HEIGHT;
            octave_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssed_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                ssed_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                ssed_pkg::CFG_OCTAVE_INDEX: octave_reg <= cfg_data[ssed_pkg::OCT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size, saturated into the supported range.
    logic [ssed_pkg::DIM_BITS-1:0] eff_w;
    logic [ssed_pkg::DIM_BITS-1:0] eff_h;

    always_comb
    begin
        if (width_reg < ssed_pkg::DIM_BITS'(ssed_pkg::MIN_DIM))
        begin
            eff_w = ssed_pkg::DIM_BITS'(ssed_pkg::MIN_DIM);
        end
        else if (width_reg > ssed_pkg::DIM_BITS'(ssed_pkg::MAX_WIDTH))
        begin
            eff_w = ssed_pkg::DIM_BITS'(ssed_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg < ssed_pkg::DIM_BITS'(ssed_pkg::MIN_DIM))
        begin
            eff_h = ssed_pkg::DIM_BITS'(ssed_pkg::MIN_DIM);
        end
        else if (height_reg > ssed_pkg::DIM_BITS'(ssed_pkg::MAX_HEIGHT))
        begin
            eff_h = ssed_pkg::DIM_BITS'(ssed_pkg::MAX_HEIGHT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    // Input handshake. Admission counts every pixel that might still produce
    // a keypoint, so the result queue can never overflow.
    logic                                 in_acc;
    logic                                 s1_valid_reg;
    logic                                 s2_valid_reg;
    logic [ssed_pkg::FIFO_CNT_BITS-1:0]   fifo_count;
    logic [ssed_pkg::FIFO_CNT_BITS-1:0]   in_flight;

    assign in_flight = fifo_count + ssed_pkg::FIFO_CNT_BITS'(s1_valid_reg)
                     + ssed_pkg::FIFO_CNT_BITS'(s2_valid_reg);
    assign s_tready  = (in_flight < ssed_pkg::FIFO_CNT_BITS'(ssed_pkg::FIFO_DEPTH));
    assign in_acc    = s_tvalid && s_tready;

    // Pixel position tracking.
    logic [ssed_pkg::POS_BITS-1:0] col_cnt_reg;
    logic [ssed_pkg::POS_BITS-1:0] row_cnt_reg;
    logic [ssed_pkg::POS_BITS-1:0] cur_col;
    logic [ssed_pkg::POS_BITS-1:0] cur_row;
    logic [ssed_pkg::POS_BITS-1:0] col_cnt_next;
    logic [ssed_pkg::POS_BITS-1:0] row_cnt_next;
    logic [ssed_pkg::DIM_BITS-1:0] col_inc;
    logic [ssed_pkg::DIM_BITS-1:0] row_inc;

    always_comb
    begin
        cur_col = col_cnt_reg;
        cur_row = row_cnt_reg;
        if (s_tuser || ({1'b0, col_cnt_reg} >= eff_w))
        begin
            cur_col = '0;
        end
        if (s_tuser || ({1'b0, row_cnt_reg} >= eff_h))
        begin
            cur_row = '0;
        end
        col_inc = {1'b0, cur_col} + 1'b1;
        row_inc = {1'b0, cur_row} + 1'b1;
        if (col_inc >= eff_w)
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_inc >= eff_h) ? '0 : row_inc[ssed_pkg::POS_BITS-1:0];
        end
        else
        begin
            col_cnt_next = col_inc[ssed_pkg::POS_BITS-1:0];
            row_cnt_next = cur_row;
        end
    end

    // Stage 1 holds the accepted pixel while its line store column is read.
    ssed_pkg::scale_set_t           s1_cur_reg;
    logic [ssed_pkg::POS_BITS-1:0]  s1_col_reg;
    logic [ssed_pkg::POS_BITS-1:0]  s1_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            if (in_acc)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cur_reg[0] <= s_tdata[15:0];
            s1_cur_reg[1] <= s_tdata[31:16];
            s1_cur_reg[2] <= s_tdata[47:32];
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
        end
    end

    // Line store: per column, the two previous rows of all three scales.
    ssed_pkg::line_word_t line_rd;
    ssed_pkg::line_word_t line_wr;

    assign line_wr.older = line_rd.newer;
    assign line_wr.newer = s1_cur_reg;

    ssed_line_buffer u_line_buffer
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (cur_col[ssed_pkg::ADDR_BITS-1:0]),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg[ssed_pkg::ADDR_BITS-1:0]),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // 3x3x3 window, indexed [scale][row][column]; the newest column sits at 2.
    ssed_pkg::sample_t              window_reg [NS][WD][WD];
    logic [ssed_pkg::POS_BITS-1:0]  s2_col_reg;
    logic [ssed_pkg::POS_BITS-1:0]  s2_row_reg;
    logic                           s2_valid_next;

    assign s2_valid_next = s1_valid_reg
                        && (s1_row_reg >= ssed_pkg::POS_BITS'(2))
                        && (s1_col_reg >= ssed_pkg::POS_BITS'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
            begin
                for (int i = 0; i < WD; i++)
                begin
                    for (int j = 0; j < WD; j++)
                    begin
                        window_reg[s][i][j] <= '0;
                    end
                end
            end
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            if (s1_valid_reg)
            begin
                for (int s = 0; s < NS; s++)
                begin
                    for (int i = 0; i < WD; i++)
                    begin
                        window_reg[s][i][0] <= window_reg[s][i][1];
                        window_reg[s][i][1] <= window_reg[s][i][2];
                    end
                    window_reg[s][0][2] <= line_rd.older[s];
                    window_reg[s][1][2] <= line_rd.newer[s];
                    window_reg[s][2][2] <= s1_cur_reg[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
        end
    end

    // Stage 2: one comparison lane per scale against the middle-scale centre.
    // The window still holds this pixel's neighborhood, since the next pixel
    // shifts it in the same edge that retires this one.
    ssed_pkg::sample_t      centre;
    ssed_pkg::sample_t      lane_taps [NS][ssed_pkg::LANE_TAPS];
    ssed_pkg::lane_flags_t  lane_flags [NS];

    assign centre = window_reg[0][1][1];

    always_comb
    begin
        for (int s = 0; s < NS; s++)
        begin
            for (int i = 0; i < WD; i++)
            begin
                for (int j = 0; j < WD; j++)
                begin
                    lane_taps[s][i * WD + j] = window_reg[s][i][j];
                end
            end
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_lane
        ssed_lane u_lane
        (
            .taps   (lane_taps[g]),
            .centre (centre),
            .flags  (lane_flags[g])
        );
    end

    // Merge: the pixel is an extremum unless some sample lies below it and
    // some other above it.
    logic            any_below;
    logic            any_above;
    logic            key_push;
    ssed_pkg::key_t  key_new;
    ssed_pkg::key_t  key_head;

    always_comb
    begin
        any_below = 1'b0;
        any_above = 1'b0;
        for (int s = 0; s < NS; s++)
        begin
            any_below = any_below | lane_flags[s].below;
            any_above = any_above | lane_flags[s].above;
        end
        key_push       = s2_valid_reg && !(any_below && any_above);
        key_new.col    = s2_col_reg - 1'b1;
        key_new.row    = s2_row_reg - 1'b1;
        key_new.value  = centre;
        key_new.octave = octave_reg;
    end

    ssed_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (key_push),
        .push_data (key_new),
        .tvalid    (m_tvalid),
        .tready    (m_tready),
        .head      (key_head),
        .count     (fifo_count)
    );

    assign m_tdata = {(48 - $bits(ssed_pkg::key_t))'(0), key_head};

endmodule
